// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro expects a signal named clk, and all but ASSERT_RST also rst, in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, off while reset is held
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also watches reset itself
`define ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

// File: src/ss_pkg.sv
package ss_pkg;

  localparam int BYTE_W        = 8;
  localparam int POS_W         = 16;
  localparam int LEN_W         = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int BYTES_PER_REG = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEEDLE_LEN     = 3'd0,
    REG_NEEDLE_BYTES_0 = 3'd1,
    REG_NEEDLE_BYTES_1 = 3'd2,
    REG_NEEDLE_BYTES_2 = 3'd3,
    REG_NEEDLE_BYTES_3 = 3'd4
  } cfg_reg_t;

  // One result beat
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
  } result_t;

endpackage

// File: src/ss_cell.sv
// One window cell: holds a recent byte, hands it on to the next cell on
// every accepted beat, and compares its byte with the needle byte it is
// lined up against.
module ss_cell (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [ss_pkg::BYTE_W-1:0] byte_in,
  input  logic [ss_pkg::BYTE_W-1:0] exp_byte,
  input  logic                      active,
  output logic [ss_pkg::BYTE_W-1:0] byte_out,
  output logic                      hit
);

  // window storage, payload only
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_out <= byte_in;
    end
  end

  // cells past the needle length always agree
  assign hit = !active || (byte_out == exp_byte);

endmodule

// File: src/ss_outbuf.sv
// Output register plus one skid entry. Stall toward the input side is the
// skid entry's valid bit, so it comes straight from a flop.
module ss_outbuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_valid,
  input  ss_pkg::result_t res,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output ss_pkg::result_t out_res
);

  logic            skid_valid;
  ss_pkg::result_t skid_res;
  logic            take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_res <= skid_res;
      end
    end else if (res_valid) begin
      if (out_valid && !take) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end
  end

endmodule

// File: src/substring_search_top.sv
// Channel  | Dir | Handshake               | Beat contents
// ---------+-----+-------------------------+-----------------------------
// input    | in  | in_valid / in_stall     | text_byte, last_byte
// output   | out | out_valid / out_stall   | found, match_position
// config   | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One haystack byte is taken every cycle unless in_stall is high; the whole
// window is compared in the same cycle by the row of cells, and the result is
// registered in the output register or its skid entry. cfg_ready is always high.
// Reset (rst, synchronous) clears the needle registers, the byte counter,
// the reported flag and both output entries.
// in_stall rises only when the output register and its skid entry are both
// full, i.e. after two results have waited on out_stall.
module substring_search_top #(
  parameter int MAX_NEEDLE = 32,
  parameter int MAX_TEXT   = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ss_pkg::BYTE_W-1:0]     text_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [ss_pkg::POS_W-1:0]      match_position,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ss_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int BW     = ss_pkg::BYTE_W;
  localparam int LEN_W  = ss_pkg::LEN_W;
  localparam int CIW    = ss_pkg::CFG_IDX_W;
  localparam int POS_W  = ss_pkg::POS_W;
  localparam int BPR    = ss_pkg::BYTES_PER_REG;
  localparam int IDX_W  = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int CNT_W  = $clog2(MAX_TEXT + 2);
  localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic [LEN_W-1:0]  needle_len;
  logic [BW-1:0]     needle [MAX_NEEDLE];
  logic [CNT_W-1:0]  byte_count;
  logic              reported;

  logic              cfg_we;
  logic              accept;
  logic [BW-1:0]     win [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0] hit;
  logic [IDX_W-1:0]  idx0;
  logic [CNT_W-1:0]  count_after;
  logic              len_ok;
  logic              cnt_ok;
  logic              match;
  logic [CMP_W-1:0]  diff;
  logic [CMP_W-1:0]  pos_sat;
  logic [POS_W-1:0]  pos;
  logic              res_valid;
  ss_pkg::result_t   res;
  ss_pkg::result_t   out_res;
  logic              buf_full;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = buf_full;

  // needle length register
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_len <= '0;
    end else if (cfg_we && cfg_index == ss_pkg::REG_NEEDLE_LEN) begin
      needle_len <= cfg_data[LEN_W-1:0];
    end
  end

  // needle bytes, eight to a register
  for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_needle
    always_ff @(posedge clk) begin
      if (rst) begin
        needle[k] <= '0;
      end else if (cfg_we &&
                   cfg_index == CIW'(ss_pkg::REG_NEEDLE_BYTES_0 + k / BPR)) begin
        needle[k] <= cfg_data[(k % BPR)*BW +: BW];
      end
    end
  end

  // newest byte sits at window position 0 and is compared here
  assign idx0   = IDX_W'(needle_len - LEN_W'(1));
  assign hit[0] = (needle_len == '0) || (text_byte == needle[idx0]);

  // row of cells holds positions 1 and up
  for (genvar i = 0; i < MAX_NEEDLE - 1; i++) begin : g_cell
    logic [BW-1:0]    byte_in;
    logic [IDX_W-1:0] exp_idx;
    logic             active;

    assign byte_in = (i == 0) ? text_byte : win[(i == 0) ? 0 : i - 1];
    assign active  = LEN_W'(i + 1) < needle_len;
    assign exp_idx = IDX_W'(needle_len - LEN_W'(1) - LEN_W'(i + 1));

    ss_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .byte_in  (byte_in),
      .exp_byte (needle[exp_idx]),
      .active   (active),
      .byte_out (win[i]),
      .hit      (hit[i+1])
    );
  end

  if (MAX_NEEDLE == 1) begin : g_no_cells
    assign win[0] = text_byte;
  end

  // match decision for this beat
  assign count_after = byte_count + CNT_W'(1);
  assign len_ok      = CMP_W'(needle_len) <= CMP_W'(MAX_NEEDLE);
  assign cnt_ok      = CMP_W'(count_after) >= CMP_W'(needle_len);
  assign match       = (&hit) && len_ok && cnt_ok && !reported;

  // start position, saturated at the largest index
  assign diff    = CMP_W'(count_after) - CMP_W'(needle_len);
  assign pos_sat = (diff > CMP_W'(MAX_TEXT - 1)) ? CMP_W'(MAX_TEXT - 1) : diff;
  assign pos     = (needle_len == '0) ? '0 : POS_W'(pos_sat);

  assign res_valid            = accept && (match || (last_byte && !reported));
  assign res.found            = match;
  assign res.match_position   = match ? pos : '0;

  // byte counter and reported flag, both restart with each haystack
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      reported   <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count <= '0;
        reported   <= 1'b0;
      end else begin
        if (byte_count < CNT_W'(MAX_TEXT)) begin
          byte_count <= count_after;
        end
        if (match) begin
          reported <= 1'b1;
        end
      end
    end
  end

  ss_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign found          = out_res.found;
  assign match_position = out_res.match_position;

endmodule

// File: src/ss_checker.sv
`include "assert_macros.svh"

// Port-level checks for the substring search block
module ss_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     found,
  input logic [ss_pkg::POS_W-1:0] match_position,
  input logic                     cfg_valid,
  input logic                     cfg_ready
);

  // a held result beat keeps its contents
  `ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(found) && $stable(match_position))

  // a not-found beat carries position zero
  `ASSERT_IMP(a_nf_pos, out_valid && !found, match_position == '0)

  // input only stalls while a result is waiting
  `ASSERT_IMP(a_stall_cause, in_stall, out_valid)

  // configuration writes are never refused
  `ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

  // reset empties the output side
  `ASSERT_RST(a_rst_empty, rst, !in_stall && !out_valid)

endmodule

bind substring_search_top ss_checker u_ss_checker (.*);

// File: sim/tb_substring_search_top.sv
module tb_substring_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NEEDLE   = 32;
  localparam int MAX_TEXT     = 65536;
  localparam int NUM_WORDS    = MAX_NEEDLE / ss_pkg::BYTES_PER_REG;
  localparam int WORD_IDX_W   = $clog2(NUM_WORDS);
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES  = 16;
  localparam int RANDOM_ITEMS = 1650;
  localparam longint TIMEOUT_NS = 20_000_000;

  typedef logic [ss_pkg::BYTE_W-1:0] text_t;
  typedef text_t text_q_t[$];

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [ss_pkg::BYTE_W-1:0]     text_byte;
  logic                          last_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic                          found;
  logic [ss_pkg::POS_W-1:0]      match_position;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [ss_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ss_pkg::CFG_DATA_W-1:0] cfg_data;

  // Predictor state: needle setup and the running haystack window
  logic [ss_pkg::LEN_W-1:0]      needle_len_q;
  logic [ss_pkg::CFG_DATA_W-1:0] needle_word [NUM_WORDS];
  text_t                         hay_window [MAX_NEEDLE];
  int unsigned                   hay_count;
  bit                            hay_reported;

  ss_pkg::result_t expected_results[$];
  int              fail_count;
  bit              sender_gaps_on;
  bit              receiver_stalls_on;
  bit              narrow_alpha;
  text_t           alpha [2];

  substring_search_top #(
    .MAX_NEEDLE(MAX_NEEDLE),
    .MAX_TEXT  (MAX_TEXT)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .text_byte     (text_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .match_position(match_position),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  // Gap lengths: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic text_t pick_text();
    if (narrow_alpha) return alpha[$urandom_range(0, 1)];
    return text_t'($urandom);
  endfunction

  function automatic text_t needle_at(input int unsigned k);
    return needle_word[(k >> 3) % NUM_WORDS][8 * (k % 8) +: 8];
  endfunction

  // Length word with random upper bits; only the low bits are the length
  function automatic logic [ss_pkg::CFG_DATA_W-1:0] make_len_word(input int unsigned len);
    logic [ss_pkg::CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    w[ss_pkg::LEN_W-1:0] = len[ss_pkg::LEN_W-1:0];
    return w;
  endfunction

  // Shift in one haystack byte and queue the result it causes, if any
  function automatic void predict_search(input text_t b, input logic last);
    int unsigned     i;
    int unsigned     len;
    int unsigned     cnt_after;
    int unsigned     pos;
    bit              hit;
    ss_pkg::result_t r;
    for (i = MAX_NEEDLE - 1; i > 0; i--) hay_window[i] = hay_window[i - 1];
    hay_window[0] = b;
    len       = needle_len_q;
    cnt_after = hay_count + 1;
    hit = !hay_reported && len <= MAX_NEEDLE && cnt_after >= len;
    for (i = 0; hit && i < len; i++) begin
      if (hay_window[len - 1 - i] != needle_at(i)) hit = 1'b0;
    end
    if (hit) begin
      pos = (len == 0) ? 0 : cnt_after - len;
      if (pos > MAX_TEXT - 1) pos = MAX_TEXT - 1;
      r.found          = 1'b1;
      r.match_position = pos[ss_pkg::POS_W-1:0];
      expected_results.push_back(r);
      hay_reported = 1'b1;
    end else if (last && !hay_reported) begin
      r.found          = 1'b0;
      r.match_position = '0;
      expected_results.push_back(r);
    end
    if (hay_count < MAX_TEXT) hay_count++;
    // end of haystack clears the search state
    if (last) begin
      hay_count    = 0;
      hay_reported = 1'b0;
      for (i = 0; i < MAX_NEEDLE; i++) hay_window[i] = '0;
    end
  endfunction

  // Output side: random stall bursts
  initial begin : drive_out_stall
    int unsigned hold;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if (receiver_stalls_on && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    ss_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: found %0d, match_position %0d",
               found, match_position);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, found);
          fail_count++;
        end
        if (match_position !== want.match_position) begin
          $error("match_position: expected %0d, actual %0d",
                 want.match_position, match_position);
          fail_count++;
        end
      end
    end
  end

  // One input beat; called and returns at a falling edge
  task automatic send_byte(input text_t b, input logic last);
    int unsigned gap;
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (in_stall);
    predict_search(b, last);
    @(negedge clk);
  endtask

  task automatic send_text(input text_q_t t);
    foreach (t[i]) send_byte(t[i], i == t.size() - 1);
  endtask

  // Stop input and let every expected result drain before touching config
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [ss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ss_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == ss_pkg::REG_NEEDLE_LEN) begin
      needle_len_q = data[ss_pkg::LEN_W-1:0];
    end else if (idx <= ss_pkg::REG_NEEDLE_BYTES_3) begin
      needle_word[WORD_IDX_W'(idx - ss_pkg::REG_NEEDLE_BYTES_0)] = data;
    end
    @(negedge clk);
  endtask

  // Unused needle bytes get random fill
  task automatic load_needle(input logic [ss_pkg::CFG_DATA_W-1:0] len_word,
                             input text_q_t nb);
    logic [ss_pkg::CFG_DATA_W-1:0] w [NUM_WORDS];
    int unsigned i;
    for (i = 0; i < NUM_WORDS; i++) w[i] = {$urandom, $urandom};
    for (i = 0; i < nb.size() && i < MAX_NEEDLE; i++) w[i / 8][8 * (i % 8) +: 8] = nb[i];
    wait_idle();
    write_reg(ss_pkg::REG_NEEDLE_LEN, len_word);
    for (i = 0; i < NUM_WORDS; i++)
      write_reg(ss_pkg::CFG_IDX_W'(int'(ss_pkg::REG_NEEDLE_BYTES_0) + i), w[i]);
    cfg_valid <= 1'b0;
  endtask

  // Reset needle length is zero, so the first byte matches at position 0
  task automatic test_reset_defaults();
    text_q_t t;
    t = '{8'h5C, 8'h00, 8'hFF};
    send_text(t);
    t = '{8'hFF};
    send_text(t);
  endtask

  task automatic test_match_and_miss();
    text_q_t nb;
    text_q_t t;
    nb = '{8'h00, 8'hFF, 8'h80};
    load_needle(make_len_word(3), nb);
    // match completed by the final byte
    t = '{8'hFF, 8'h00, 8'hFF, 8'h80};
    send_text(t);
    // two occurrences, only the first is reported, nothing at the end
    t = '{8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h80};
    send_text(t);
    // near miss
    t = '{8'h00, 8'hFF, 8'h7F};
    send_text(t);
    // needle split across two haystacks must not match
    t = '{8'h00, 8'hFF};
    send_text(t);
    t = '{8'h80};
    send_text(t);
  endtask

  task automatic test_empty_needle();
    text_q_t nb;
    text_q_t t;
    nb = '{8'h80, 8'h01};
    load_needle(make_len_word(0), nb);
    t = '{8'h80, 8'h01};
    send_text(t);
    t = '{8'h00};
    send_text(t);
  endtask

  task automatic test_full_needle();
    text_q_t nb;
    text_q_t t;
    int unsigned i;
    for (i = 0; i < MAX_NEEDLE; i++) nb.push_back(text_t'($urandom));
    load_needle(make_len_word(MAX_NEEDLE), nb);
    send_text(nb);
    t = '{8'h00, 8'hFF, 8'h00};
    foreach (nb[k]) t.push_back(nb[k]);
    send_text(t);
  endtask

  // Lengths above the window never match
  task automatic test_oversize_len();
    text_q_t nb;
    text_q_t t;
    int unsigned i;
    for (i = 0; i < MAX_NEEDLE; i++) nb.push_back(text_t'($urandom));
    load_needle(make_len_word(MAX_NEEDLE + 1), nb);
    t = nb;
    t.push_back(nb[0]);
    send_text(t);
    load_needle(make_len_word((1 << ss_pkg::LEN_W) - 1), nb);
    send_text(nb);
  endtask

  // Writes past the last register must change nothing
  task automatic test_unused_index();
    text_q_t nb;
    text_q_t t;
    int unsigned idx;
    nb = '{8'h41, 8'h42};
    load_needle(make_len_word(2), nb);
    wait_idle();
    for (idx = int'(ss_pkg::REG_NEEDLE_BYTES_3) + 1; idx < (1 << ss_pkg::CFG_IDX_W); idx++)
      write_reg(ss_pkg::CFG_IDX_W'(idx), {$urandom, $urandom});
    cfg_valid <= 1'b0;
    t = '{8'h41, 8'h41, 8'h42, 8'h43};
    send_text(t);
  endtask

  task automatic test_random_haystacks(input int unsigned item_goal);
    text_q_t     nb;
    text_q_t     hay;
    int unsigned sent;
    int unsigned phase_sent;
    int unsigned phase_goal;
    int unsigned phase;
    int unsigned len;
    int unsigned ins;
    int unsigned hay_len;
    int unsigned s;
    int unsigned c;
    int unsigned k;
    int unsigned r;
    sent  = 0;
    phase = 0;
    while (sent < item_goal) begin
      // new setting: extremes first, then random lengths
      case (phase)
        0: len = MAX_NEEDLE;
        1: len = 1;
        2: len = 0;
        3: len = (1 << ss_pkg::LEN_W) - 1;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 8) len = 0;
          else if (r < 20) len = 1;
          else if (r < 55) len = $urandom_range(2, 8);
          else if (r < 85) len = $urandom_range(9, MAX_NEEDLE - 1);
          else if (r < 93) len = MAX_NEEDLE;
          else len = $urandom_range(MAX_NEEDLE + 1, (1 << ss_pkg::LEN_W) - 1);
        end
      endcase
      narrow_alpha = $urandom_range(0, 1);
      alpha[0] = text_t'($urandom);
      alpha[1] = text_t'($urandom);
      nb.delete();
      for (k = 0; k < MAX_NEEDLE; k++) nb.push_back(pick_text());
      load_needle(make_len_word(len), nb);
      sender_gaps_on     = ($urandom_range(0, 3) != 0);
      receiver_stalls_on = ($urandom_range(0, 3) != 0);
      phase_goal = $urandom_range(120, 220);
      phase_sent = 0;
      while (phase_sent < phase_goal) begin
        hay_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 40)
                                              : $urandom_range(41, 120);
        hay.delete();
        repeat (hay_len) hay.push_back(pick_text());
        // mostly plant the needle, sometimes cut short or with one bit flipped
        if ($urandom_range(0, 99) < 70) begin
          ins = (needle_len_q > MAX_NEEDLE) ? MAX_NEEDLE : needle_len_q;
          if (hay_len >= ins && $urandom_range(0, 5) == 0) s = hay_len - ins;
          else s = $urandom_range(0, hay_len - 1);
          for (k = 0; k < ins && s + k < hay_len; k++) hay[s + k] = needle_at(k);
          if (ins > 0 && $urandom_range(0, 4) == 0) begin
            c = $urandom_range(0, ins - 1);
            if (s + c < hay_len) hay[s + c] ^= text_t'(1 << $urandom_range(0, 7));
          end
        end
        send_text(hay);
        phase_sent += hay_len;
      end
      sent += phase_sent;
      phase++;
    end
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  initial begin : run_tests
    int unsigned i;
    rst                = 1'b1;
    in_valid           = 1'b0;
    text_byte          = '0;
    last_byte          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = ss_pkg::REG_NEEDLE_LEN;
    cfg_data           = '0;
    fail_count         = 0;
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    narrow_alpha       = 1'b0;
    needle_len_q       = '0;
    hay_count          = 0;
    hay_reported       = 1'b0;
    for (i = 0; i < NUM_WORDS; i++) needle_word[i] = '0;
    for (i = 0; i < MAX_NEEDLE; i++) hay_window[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_match_and_miss();
    test_empty_needle();
    test_full_needle();
    test_oversize_len();
    test_unused_index();
    test_random_haystacks(RANDOM_ITEMS);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
